// ===== rtl/core/oahi_pkg.sv =====
// oahi_pkg: shared types and constants for the open-addressing hash insert unit
// no dependencies
`timescale 1ns / 1ps

package oahi_pkg;

    localparam int KEY_W   = 31;
    localparam int VAL_W   = 31;
    localparam int SIZE_W  = 11;
    localparam int MODE_W  = 2;
    localparam int SLOT_W  = 10;
    localparam int CFG_W   = 11;
    localparam int CIDX_W  = 1;

    localparam logic [CIDX_W-1:0] CFG_TABLE_SIZE = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_PROBE_MODE = 1'b1;

    localparam logic [MODE_W-1:0] MODE_LINEAR    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUADRATIC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DOUBLE    = 2'd2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic              inserted;
        logic [SLOT_W-1:0] slot;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture transaction, start modulo
        logic mod_step;   // one restoring division step
        logic probe_init; // set up probe counter and position
        logic rd;         // issue memory read at current position
        logic probe_next; // advance to next probe position
        logic wr;         // write value at current position
        logic clr_start;  // start clearing sweep
        logic clr_step;   // clear one entry
        logic res_ok;     // capture successful result
        logic res_fail;   // capture empty result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic mod_done;
        logic slot_empty;
        logic last_probe;
        logic clr_done;
        logic is_clear;
    } t_dp_sts;

endpackage

// ===== rtl/core/open_addressing_hash_insert.sv =====
// an insert runs the bit-serial modulo, then reads and checks one slot per probe; a clear sweeps every slot
// throughput: one transaction at a time; a result still waiting holds the next one at its end
// reset: synchronous active low; after reset a sweep empties the slot
// memory, input ready stays low until it ends; table_size resets to 1024, probe_mode to 0
// depends on oahi_pkg, oahi_ctrl, oahi_datapath
`timescale 1ns / 1ps

module open_addressing_hash_insert #(
    parameter int SLOTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  oahi_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output oahi_pkg::t_out_item           o_out_data,
    input  logic                          i_cfg_we,
    input  logic [oahi_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [oahi_pkg::CFG_W-1:0]    i_cfg_data
);
    import oahi_pkg::*;

    logic [SIZE_W-1:0] r_table_size;
    logic [MODE_W-1:0] r_probe_mode;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= SIZE_W'(1024);
            r_probe_mode <= MODE_LINEAR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TABLE_SIZE: r_table_size <= i_cfg_data;
                CFG_PROBE_MODE: r_probe_mode <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    oahi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    oahi_datapath #(.SLOTS(SLOTS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in_data),
        .i_size   (r_table_size),
        .i_mode   (r_probe_mode),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_result (o_out_data)
    );

endmodule

// ===== rtl/core/oahi_datapath.sv =====
// oahi_datapath: slot memory, bit-serial modulo, probe address generation
// depends on oahi_pkg
`timescale 1ns / 1ps

module oahi_datapath #(
    parameter int SLOTS = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  oahi_pkg::t_in_item      i_item,
    input  logic [oahi_pkg::SIZE_W-1:0] i_size,
    input  logic [oahi_pkg::MODE_W-1:0] i_mode,
    input  oahi_pkg::t_dp_cmd       i_cmd,
    output oahi_pkg::t_dp_sts       o_sts,
    output oahi_pkg::t_out_item     o_result
);
    import oahi_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW = AW + 1;   // positions and sizes up to SLOTS
    localparam int MCNT_W = $clog2(KEY_W + 1);

    logic [31:0] r_mem [SLOTS];
    logic [31:0] r_rd_data;

    logic [VAL_W-1:0]  r_value;
    logic              r_is_clear;
    logic [KEY_W-1:0]  r_quot;
    logic [PW-1:0]     r_rem;
    logic [MCNT_W-1:0] r_mcnt;
    logic [PW-1:0]     r_size;
    logic [PW-1:0]     r_pos;
    logic [PW-1:0]     r_step;   // per-probe increment
    logic [PW-1:0]     r_iter;
    logic [AW-1:0]     r_clr;
    logic              r_clr_done;
    t_out_item         r_result;

    logic [PW-1:0]     w_eff;
    logic [PW:0]       w_trial;
    logic [PW-1:0]     n_rem;
    logic [PW:0]       w_sum;
    logic [PW-1:0]     w_pos_next;
    logic [PW:0]       w_stp;
    logic [PW-1:0]     w_step_next;
    logic [PW-1:0]     w_dstep;
    logic [31:0]       w_q0_w;
    logic [31:0]       w_ten_w;
    logic [PW-1:0]     w_q0;
    logic [PW-1:0]     w_ten;

    // effective table size: zero becomes one, saturate at SLOTS
    always_comb begin
        if (i_size == '0) begin
            w_eff = PW'(1);
        end else if ({21'd0, i_size} > 32'(SLOTS)) begin
            w_eff = PW'(SLOTS);
        end else begin
            w_eff = PW'(i_size);
        end
    end

    // restoring division step: shift in next key bit
    always_comb begin
        w_trial = {r_rem, r_quot[KEY_W-1]};
        if (w_trial >= {1'b0, r_size}) begin
            n_rem = PW'(w_trial - {1'b0, r_size});
        end else begin
            n_rem = PW'(w_trial);
        end
    end

    // double-hash step: home, zero becomes one
    // quadratic constants 7 and 10 reduced modulo size by table
    always_comb begin
        w_dstep = (r_rem == '0) ? PW'(1) : r_rem;
        unique case (32'(r_size))
            32'd1: begin
                w_q0_w  = 32'd0;
                w_ten_w = 32'd0;
            end
            32'd2: begin
                w_q0_w  = 32'd1;
                w_ten_w = 32'd0;
            end
            32'd3: begin
                w_q0_w  = 32'd1;
                w_ten_w = 32'd1;
            end
            32'd4: begin
                w_q0_w  = 32'd3;
                w_ten_w = 32'd2;
            end
            32'd5: begin
                w_q0_w  = 32'd2;
                w_ten_w = 32'd0;
            end
            32'd6: begin
                w_q0_w  = 32'd1;
                w_ten_w = 32'd4;
            end
            32'd7: begin
                w_q0_w  = 32'd0;
                w_ten_w = 32'd3;
            end
            32'd8: begin
                w_q0_w  = 32'd7;
                w_ten_w = 32'd2;
            end
            32'd9: begin
                w_q0_w  = 32'd7;
                w_ten_w = 32'd1;
            end
            32'd10: begin
                w_q0_w  = 32'd7;
                w_ten_w = 32'd0;
            end
            default: begin
                w_q0_w  = 32'd7;
                w_ten_w = 32'd10;
            end
        endcase
        w_q0  = PW'(w_q0_w);
        w_ten = PW'(w_ten_w);
    end

    // next probe position, all terms kept below size
    always_comb begin
        w_sum = {1'b0, r_pos} + {1'b0, r_step};
        if (w_sum >= {1'b0, r_size}) begin
            w_pos_next = PW'(w_sum - {1'b0, r_size});
        end else begin
            w_pos_next = PW'(w_sum);
        end
        // quadratic increment grows by 10 each probe: 7, 17, 27 ...
        w_stp = {1'b0, r_step} + {1'b0, w_ten};
        if (w_stp >= {1'b0, r_size}) begin
            w_stp = w_stp - {1'b0, r_size};
        end
        if (i_mode == MODE_QUADRATIC) begin
            w_step_next = PW'(w_stp);
        end else begin
            w_step_next = r_step;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_done <= 1'b0;
            r_clr      <= '0;
        end else if (i_cmd.clr_start) begin
            r_clr      <= '0;
            r_clr_done <= 1'b0;
        end else if (i_cmd.clr_step) begin
            r_clr      <= r_clr + AW'(1);
            r_clr_done <= (32'(r_clr) == 32'(SLOTS - 1));
        end
    end

    // transaction capture, modulo and probe registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value    <= i_item.value;
            r_is_clear <= (i_item.command == CMD_CLEAR);
            r_quot     <= i_item.key;
            r_rem      <= '0;
            r_mcnt     <= '0;
            r_size     <= w_eff;
        end else if (i_cmd.mod_step) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[KEY_W-2:0], 1'b0};
            r_mcnt <= r_mcnt + MCNT_W'(1);
        end
        if (i_cmd.probe_init) begin
            r_pos  <= r_rem;
            r_iter <= '0;
            if (i_mode == MODE_QUADRATIC) begin
                r_step <= w_q0;
            end else if (i_mode == MODE_DOUBLE) begin
                r_step <= w_dstep;
            end else begin
                r_step <= (r_size == PW'(1)) ? '0 : PW'(1);
            end
        end else if (i_cmd.probe_next) begin
            r_pos  <= w_pos_next;
            r_step <= w_step_next;
            r_iter <= r_iter + PW'(1);
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[r_clr] <= '1;
        end else if (i_cmd.wr) begin
            r_mem[r_pos[AW-1:0]] <= {1'b0, r_value};
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_pos[AW-1:0]];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ok) begin
            r_result.inserted <= 1'b1;
            r_result.slot     <= SLOT_W'(r_pos);
        end else if (i_cmd.res_fail) begin
            r_result.inserted <= 1'b0;
            r_result.slot     <= '0;
        end
    end

    assign o_sts.mod_done   = (32'(r_mcnt) == 32'(KEY_W));
    assign o_sts.slot_empty = (r_rd_data == '1);
    assign o_sts.last_probe = (r_iter + PW'(1) == r_size);
    assign o_sts.clr_done   = r_clr_done;
    assign o_sts.is_clear   = r_is_clear;
    assign o_result         = r_result;

endmodule

// ===== rtl/core/oahi_ctrl.sv =====
// oahi_ctrl: sequencer for modulo, probe loop, clearing sweep and handshakes
// depends on oahi_pkg
`timescale 1ns / 1ps

module oahi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  oahi_pkg::t_dp_sts i_sts,
    output oahi_pkg::t_dp_cmd o_cmd
);
    import oahi_pkg::*;

    typedef enum logic [7:0] {
        S_RESET_CLR = 8'b0000_0001,
        S_IDLE      = 8'b0000_0010,
        S_MOD       = 8'b0000_0100,
        S_READ      = 8'b0000_1000,
        S_CHECK     = 8'b0001_0000,
        S_CLEAR     = 8'b0010_0000,
        S_DONE      = 8'b0100_0000,
        S_WAIT      = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_res_free;

    // result register may be reloaded only once the waiting result leaves
    assign w_res_free = !r_out_valid || i_out_ready;

    // next-state and command logic; output register hand-off: a result may wait while idle
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_RESET_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    o_cmd.clr_step = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                if (i_sts.is_clear) begin
                    o_cmd.clr_start = 1'b1;
                    n_state = S_CLEAR;
                end else if (i_sts.mod_done) begin
                    o_cmd.probe_init = 1'b1;
                    n_state = S_READ;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                if (!w_res_free) begin
                    n_state = S_CHECK;
                end else if (i_sts.slot_empty) begin
                    o_cmd.wr     = 1'b1;
                    o_cmd.res_ok = 1'b1;
                    n_state = S_DONE;
                end else if (i_sts.last_probe) begin
                    o_cmd.res_fail = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state = S_READ;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    o_cmd.clr_step = 1'b0;
                    if (w_res_free) begin
                        o_cmd.res_fail = 1'b1;
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RESET_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/oahi_checker.sv =====
// oahi_checker: port-level assertions for the hash insert unit, bound to the top level
// depends on oahi_pkg
`timescale 1ns / 1ps

module oahi_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input oahi_pkg::t_out_item o_out_data
);
    import oahi_pkg::*;

    // a failed insert or clear reports slot zero
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.inserted |-> o_out_data.slot == '0)
        else $error("failed transaction with nonzero slot");

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction dropped or changed");

    // no new input is taken the cycle after one was accepted
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while busy");

    // no result the cycle after an accept
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result appeared too early");

endmodule

bind open_addressing_hash_insert oahi_checker u_oahi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== tb/sv/tb_open_addressing_hash_insert.sv =====
// tb_open_addressing_hash_insert: self-checking bench for the open-addressing hash insert unit
// drives inserts and clears under several table sizes and probe modes, predicts slot choices
// depends on oahi_pkg and open_addressing_hash_insert
`timescale 1ns / 1ps

module tb_open_addressing_hash_insert;
    import oahi_pkg::*;

    localparam int NSLOTS   = 1024;
    localparam int WD_LIMIT = 400000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in_item          i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out_item         o_out_data;
    logic              i_cfg_we;
    logic [CIDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;

    open_addressing_hash_insert #(.SLOTS(NSLOTS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // shadow copy of the table and registers
    logic [31:0]       shadow_slots [NSLOTS];
    logic [SIZE_W-1:0] shadow_size;
    logic [MODE_W-1:0] shadow_mode;

    t_in_item  pending_items [$];
    t_out_item expected_results [$];
    bit        idle_free;
    int        mismatches;
    int        results_seen;
    int        stall_cycles;
    int        inserts_ok;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // compute the result of an insert or clear and update the shadow table
    function automatic t_out_item predict_insert(t_in_item it);
        t_out_item r;
        longint unsigned sz, home, stride, offs, pos;
        r = '0;
        if (it.command == CMD_CLEAR) begin
            for (int k = 0; k < NSLOTS; k++) shadow_slots[k] = '1;
            return r;
        end
        sz = shadow_size;
        if (sz == 0) sz = 1;
        if (sz > NSLOTS) sz = NSLOTS;
        home = it.key % sz;
        stride = (home % sz == 0) ? 1 : home % sz;
        for (longint unsigned i = 0; i < sz; i++) begin
            if (shadow_mode == MODE_QUADRATIC) offs = 2 * i + 5 * i * i;
            else if (shadow_mode == MODE_DOUBLE) offs = i * stride;
            else offs = i;
            pos = (home + offs) % sz;
            if (shadow_slots[pos] == 32'hFFFF_FFFF) begin
                shadow_slots[pos] = {1'b0, it.value};
                r.inserted = 1'b1;
                r.slot = pos[SLOT_W-1:0];
                return r;
            end
        end
        return r;
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pending_items.size() > 0 && (idle_free || $urandom_range(99) >= 27)) begin
                i_in_data  <= pending_items[0];
                expected_results.push_back(predict_insert(pending_items.pop_front()));
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= idle_free || ($urandom_range(99) >= 27);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result %p", o_out_data);
            end else begin
                if (o_out_data.inserted !== expected_results[0].inserted ||
                    o_out_data.slot !== expected_results[0].slot) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected inserted=%0d slot=%0d, got inserted=%0d slot=%0d",
                            expected_results[0].inserted, expected_results[0].slot,
                            o_out_data.inserted, o_out_data.slot);
                end
                if (expected_results[0].inserted) inserts_ok <= inserts_ok + 1;
                void'(expected_results.pop_front());
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > WD_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_TABLE_SIZE) shadow_size = val[SIZE_W-1:0];
        else shadow_mode = val[MODE_W-1:0];
    endtask

    task automatic add_item(input logic cmd, input logic [30:0] k, input logic [30:0] v);
        t_in_item it;
        it.command = cmd;
        it.key = k;
        it.value = v;
        pending_items.push_back(it);
    endtask

    // wait until all transactions drained, then give a clear sweep time to finish
    task automatic drain();
        while (pending_items.size() > 0 || expected_results.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (NSLOTS + 50) @(posedge i_clk);
    endtask

    // phase: random fill under one setting, mostly inserts with occasional clears
    task automatic random_phase(input int sz, input int md, input int n);
        write_reg(CFG_TABLE_SIZE, sz);
        write_reg(CFG_PROBE_MODE, md);
        add_item(CMD_CLEAR, $urandom, $urandom);
        for (int j = 0; j < n; j++) begin
            if ($urandom_range(99) < 4) add_item(CMD_CLEAR, $urandom, $urandom);
            else if ($urandom_range(3) == 0) add_item(CMD_INSERT, $urandom, $urandom);
            else add_item(CMD_INSERT, $urandom_range(200), $urandom);
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        idle_free = 1'b0;
        mismatches = 0;
        results_seen = 0;
        stall_cycles = 0;
        inserts_ok = 0;
        shadow_size = 11'd1024;
        shadow_mode = MODE_LINEAR;
        for (int k = 0; k < NSLOTS; k++) shadow_slots[k] = '1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme fields at reset setting, collisions, clear
        add_item(CMD_INSERT, '0, '0);
        add_item(CMD_INSERT, '1, '1);
        add_item(CMD_INSERT, 31'd1024, 31'h2AAA_AAAA);
        add_item(CMD_INSERT, 31'd2048, 31'h5555_5555);
        add_item(CMD_INSERT, 31'd1023, 31'd7);
        add_item(CMD_CLEAR, '1, '1);
        add_item(CMD_INSERT, 31'd5, 31'd9);
        drain();
        // zero size acts as one slot, second insert finds table full
        write_reg(CFG_TABLE_SIZE, 0);
        write_reg(CFG_PROBE_MODE, 3);
        add_item(CMD_CLEAR, '0, '0);
        add_item(CMD_INSERT, 31'd77, 31'd1);
        add_item(CMD_INSERT, 31'd78, 31'd2);
        drain();
        // oversize saturates under quadratic mode, then double mode on a tiny table
        write_reg(CFG_TABLE_SIZE, 2047);
        write_reg(CFG_PROBE_MODE, MODE_QUADRATIC);
        add_item(CMD_INSERT, 31'd3, 31'd3);
        add_item(CMD_INSERT, 31'd3, 31'd4);
        drain();
        write_reg(CFG_TABLE_SIZE, 7);
        write_reg(CFG_PROBE_MODE, MODE_DOUBLE);
        add_item(CMD_CLEAR, '0, '0);
        for (int j = 0; j < 9; j++) add_item(CMD_INSERT, 31'd14 + j[30:0] % 3, j[30:0]);
        drain();

        // random phases across sizes and modes, one stretch without idling
        random_phase(8, MODE_LINEAR, 60);
        random_phase(13, MODE_QUADRATIC, 80);
        idle_free = 1'b1;
        random_phase(16, MODE_DOUBLE, 80);
        idle_free = 1'b0;
        random_phase(1, MODE_DOUBLE, 20);
        random_phase(1024, MODE_QUADRATIC, 120);
        random_phase(37, 3, 80);
        random_phase(1024, MODE_LINEAR, 100);
        random_phase(64, MODE_DOUBLE, 80);

        $display("covered %0d results, %0d successful inserts, sizes 0 to 2047, all probe modes",
            results_seen, inserts_ok);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
